### rtl/kmt_pkg.sv
// ----------------------------------------------------------------------------
// kmt_pkg
// Shared field widths for the knot multiplicity table and its checker.
// ----------------------------------------------------------------------------
package kmt_pkg;

  localparam int KNOT_W      = 32;
  localparam int TOL_W       = 17;
  localparam int INDEX_OUT_W = 6;
  localparam int MULT_OUT_W  = 16;

  typedef logic signed [KNOT_W-1:0] knot_t;
  typedef logic [TOL_W-1:0]         tol_t;
  typedef logic [INDEX_OUT_W-1:0]   index_out_t;
  typedef logic [MULT_OUT_W-1:0]    mult_out_t;

endpackage

### rtl/kmt_ram.sv
// ----------------------------------------------------------------------------
// kmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/knot_multiplicity_table.sv
// ----------------------------------------------------------------------------
// knot_multiplicity_table
// Counts multiplicities of distinct Q16.16 knot values.
// ----------------------------------------------------------------------------
// Each beat on the input carries one knot value. The block compares it against
// the stored distinct knots in insertion order, one entry per cycle through a
// single subtract/compare unit reading the knot memory, and stops at the first
// entry within match_tolerance. A match bumps that entry's count (saturating);
// otherwise the value is appended with count one, or dropped with table_full
// when no entry is free. in_ready is high only in the idle state, so an item
// is taken only after the search of the last one and the loading of its
// result; in_ready stays low longer while an earlier result still waits in
// the output register. That register lets a new item be taken while its
// result waits. The table empties at reset through its fill count, with no
// clearing pass. cfg_data writes match_tolerance (reset 1, exact match);
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module knot_multiplicity_table
  import kmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  tol_t       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  knot_t      knot_value,
  output logic       out_valid,
  input  logic       out_ready,
  output index_out_t entry_index,
  output mult_out_t  multiplicity,
  output logic       is_new,
  output logic       table_full
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_W  = KNOT_W + COUNT_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]             state;
  logic [IDX_W-1:0]       cur_idx;
  logic [USED_W-1:0]      used;
  tol_t                   tol;
  logic [KNOT_W-1:0]      knot;
  logic [IDX_W-1:0]       res_idx;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   res_new;
  logic                   res_full;

  logic [IDX_W-1:0]       rd_addr;
  logic [RAM_W-1:0]       rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [RAM_W-1:0]       wr_data;

  logic [KNOT_W-1:0]      stored_knot;
  logic [COUNT_WIDTH-1:0] stored_count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [KNOT_W:0]        diff;
  logic [KNOT_W:0]        diff_mag;
  logic                   match;
  logic                   in_range;
  logic                   hit;
  logic                   last;
  logic                   has_room;
  logic                   append;
  logic                   load_out;

  logic [IDX_W+INDEX_OUT_W-1:0]      idx_ext;
  logic [COUNT_WIDTH+MULT_OUT_W-1:0] mult_ext;

  kmt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign stored_knot  = rd_data[RAM_W-1 -: KNOT_W];
  assign stored_count = rd_data[COUNT_WIDTH-1:0];

  always_comb begin
    diff     = {stored_knot[KNOT_W-1], stored_knot} - {knot[KNOT_W-1], knot};
    diff_mag = diff[KNOT_W] ? (~diff + {{KNOT_W{1'b0}}, 1'b1}) : diff;
    match    = diff_mag < {{(KNOT_W + 1 - TOL_W){1'b0}}, tol};
  end

  assign in_range  = USED_W'(cur_idx) < used;
  assign hit       = (state == ST_SEARCH) && in_range && match;
  assign last      = (USED_W'(cur_idx) + USED_W'(1)) >= used;
  assign has_room  = used != USED_W'(TABLE_DEPTH);
  assign append    = (state == ST_SEARCH) && !hit && last && has_room;
  assign count_inc = (&stored_count) ? stored_count : stored_count + COUNT_WIDTH'(1);

  // registered read: data in SEARCH belongs to cur_idx
  assign rd_addr = (state == ST_SEARCH) ? cur_idx + IDX_W'(1) : '0;
  assign wr_en   = hit || append;
  assign wr_addr = hit ? cur_idx : used[IDX_W-1:0];
  assign wr_data = hit ? {stored_knot, count_inc} : {knot, COUNT_WIDTH'(1)};

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign load_out  = (state == ST_DONE) && (!out_valid || out_ready);

  assign idx_ext  = {{INDEX_OUT_W{1'b0}}, res_idx};
  assign mult_ext = {{MULT_OUT_W{1'b0}}, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      tol       <= TOL_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit || last) begin
            state <= ST_DONE;
          end
          if (append) begin
            used <= used + USED_W'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      knot    <= knot_value;
      cur_idx <= '0;
    end
    if (state == ST_SEARCH) begin
      if (hit) begin
        res_idx   <= cur_idx;
        res_count <= count_inc;
        res_new   <= 1'b0;
        res_full  <= 1'b0;
      end else if (last) begin
        if (has_room) begin
          res_idx   <= used[IDX_W-1:0];
          res_count <= COUNT_WIDTH'(1);
          res_new   <= 1'b1;
          res_full  <= 1'b0;
        end else begin
          res_idx   <= '0;
          res_count <= '0;
          res_new   <= 1'b0;
          res_full  <= 1'b1;
        end
      end else begin
        cur_idx <= cur_idx + IDX_W'(1);
      end
    end
    if (load_out) begin
      entry_index  <= idx_ext[INDEX_OUT_W-1:0];
      multiplicity <= mult_ext[MULT_OUT_W-1:0];
      is_new       <= res_new;
      table_full   <= res_full;
    end
  end

endmodule

### rtl/kmt_checker.sv
// ----------------------------------------------------------------------------
// kmt_checker
// Port-level checks for the knot multiplicity table, bound to the top level.
// ----------------------------------------------------------------------------
module kmt_checker
  import kmt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input knot_t      knot_value,
  input logic       out_valid,
  input logic       out_ready,
  input index_out_t entry_index,
  input mult_out_t  multiplicity,
  input logic       is_new,
  input logic       table_full
);

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(knot_value))
    else $error("waiting input beat changed");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_index)
      && $stable(multiplicity) && $stable(is_new) && $stable(table_full))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !is_new && multiplicity == '0 && entry_index == '0)
    else $error("dropped beat carries nonzero fields");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> multiplicity == MULT_OUT_W'(1) && !table_full)
    else $error("new knot without count one");

endmodule

bind knot_multiplicity_table kmt_checker u_kmt_checker (.*);
